/* hw/rtl/elm_pkg.sv */
// shared types, constants and helper functions for the edge latency meter
`default_nettype none

package elm_pkg;

  // field widths
  localparam int LINE_ID_W   = 4;
  localparam int SAMPLE_W    = 32;
  localparam int TIME_W      = 63;
  localparam int LATENCY_W   = 32;
  localparam int ACK_LINE_W  = 16;
  localparam int ACK_MS_W    = 14;
  localparam int ACK_US_W    = 24;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // default line count and milliseconds to microseconds scale
  localparam int DEFAULT_LINES = 16;
  localparam int ACK_SCALE     = 1000;

  // configuration reset values
  localparam logic [ACK_LINE_W-1:0] ACK_LINE_RESET = ACK_LINE_W'(8);
  localparam logic [ACK_MS_W-1:0]   ACK_MS_RESET   = ACK_MS_W'(25);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE      = 4'd0,
    REG_TRIGGER   = 4'd1,
    REG_ACK_LINE  = 4'd2,
    REG_ACK_PULSE = 4'd3
  } cfg_reg_t;

  // measurement mode
  typedef enum logic {
    MODE_DUAL   = 1'b0,
    MODE_SINGLE = 1'b1
  } mode_t;

  // edge qualification codes, the unused code never qualifies
  typedef enum logic [1:0] {
    EDGE_RISE = 2'd0,
    EDGE_FALL = 2'd1,
    EDGE_ANY  = 2'd2
  } trig_t;

  // reading source
  typedef enum logic {
    SRC_A = 1'b0,
    SRC_B = 1'b1
  } src_t;

  // request into the last-value store
  typedef struct packed {
    logic                 write;
    src_t                 src;
    logic [LINE_ID_W-1:0] line_id;
    logic [SAMPLE_W-1:0]  value;
  } store_req_t;

  // edge qualification of a new value against the kept one
  function automatic logic qualify(input logic [SAMPLE_W-1:0] prev,
                                   input logic [SAMPLE_W-1:0] now,
                                   input logic [1:0]          trig);
    logic hit;
    hit = 1'b0;
    unique case (trig)
      EDGE_RISE: hit = (prev == '0) && (now != '0);
      EDGE_FALL: hit = (prev != '0) && (now == '0);
      EDGE_ANY:  hit = (prev != now);
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

  // later minus earlier, saturated to signed 32 bits
  function automatic logic [LATENCY_W-1:0] sat_diff(input logic [TIME_W-1:0] later,
                                                    input logic [TIME_W-1:0] earlier);
    logic [TIME_W:0] d;
    logic [LATENCY_W-1:0] res;
    d = {1'b0, later} - {1'b0, earlier};
    if ((&d[TIME_W:LATENCY_W-1]) || !(|d[TIME_W:LATENCY_W-1])) begin
      res = d[LATENCY_W-1:0];
    end else if (d[TIME_W]) begin
      res = {1'b1, {(LATENCY_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(LATENCY_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/elm_if.sv */
// channel interfaces: line readings in, measurements out, configuration writes
`default_nettype none

interface elm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [elm_pkg::LINE_ID_W-1:0] line_id;
  logic [elm_pkg::SAMPLE_W-1:0]  sample_value;
  logic [elm_pkg::TIME_W-1:0]    sample_time_us;

  modport source (output valid, action, line_id, sample_value, sample_time_us,
                  input ready);
  modport sink (input valid, action, line_id, sample_value, sample_time_us,
                output ready);
endinterface

interface elm_out_if;
  logic                                valid;
  logic                                ready;
  logic                                has_latency;
  logic signed [elm_pkg::LATENCY_W-1:0] latency_us;
  logic [elm_pkg::TIME_W-1:0]          measure_time_us;
  logic                                fire_ack;
  logic [elm_pkg::ACK_LINE_W-1:0]      ack_line_out;
  logic [elm_pkg::ACK_US_W-1:0]        ack_duration_us;

  modport source (output valid, has_latency, latency_us, measure_time_us, fire_ack,
                  ack_line_out, ack_duration_us, input ready);
  modport sink (input valid, has_latency, latency_us, measure_time_us, fire_ack,
                ack_line_out, ack_duration_us, output ready);
endinterface

interface elm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [elm_pkg::CFG_INDEX_W-1:0] index;
  logic [elm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/elm_line_store.sv */
// last-value store per line and source, with edge qualification on the read side
`default_nettype none

module elm_line_store #(
  parameter int DEPTH = elm_pkg::DEFAULT_LINES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire elm_pkg::store_req_t req,
  input  wire logic [1:0]          trig_sel,
  output logic                     hit
);
  import elm_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SAMPLE_W-1:0] last_a [DEPTH];
  logic [SAMPLE_W-1:0] last_b [DEPTH];
  logic [IDX_W-1:0]    idx;
  logic [SAMPLE_W-1:0] prev;

  assign idx = req.line_id[IDX_W-1:0];

  // kept value of the addressed line, then qualify the new one
  always_comb begin
    prev = (req.src == SRC_A) ? last_a[idx] : last_b[idx];
    hit  = qualify(prev, req.value, trig_sel);
  end

  // update the kept value on every in-range reading
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        last_a[i] <= '0;
        last_b[i] <= '0;
      end
    end else if (req.write) begin
      if (req.src == SRC_A) begin
        last_a[idx] <= req.value;
      end else begin
        last_b[idx] <= req.value;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/edge_latency_meter.sv */
// edge latency meter top level: edge qualification, interval timing, result register
// a result is valid in the cycle after the reading's transaction
// throughput: one reading per cycle unless stalled; single result register, bypassed ready
// per line last values are read and rewritten in the cycle of the transaction
// reset clears all kept values, pending and previous marks and restores configuration defaults
// no clearing pass after reset: readings are taken in the first cycle after reset drops
`default_nettype none

module edge_latency_meter #(
  parameter int LINES = elm_pkg::DEFAULT_LINES
) (
  input wire logic clk,
  input wire logic rst,
  elm_in_if.sink   in_ch,
  elm_out_if.source out_ch,
  elm_cfg_if.sink  cfg
);
  import elm_pkg::*;

  localparam int   DEPTH   = (LINES < (1 << LINE_ID_W)) ? LINES : (1 << LINE_ID_W);
  localparam logic ALL_IN  = (LINES >= (1 << LINE_ID_W));

  // configuration registers
  logic                  mode;
  logic [1:0]            trig_sel;
  logic [ACK_LINE_W-1:0] pulse_line;
  logic [ACK_MS_W-1:0]   pulse_ms;

  // measurement state
  logic [TIME_W-1:0] pending_time;
  logic              pending_valid;
  logic [TIME_W-1:0] previous_time;
  logic              previous_valid;

  // result register
  logic                  out_valid;
  logic                  has_latency;
  logic [LATENCY_W-1:0]  latency_us;
  logic [TIME_W-1:0]     measure_time_us;
  logic [ACK_LINE_W-1:0] ack_line_out;
  logic [ACK_US_W-1:0]   ack_duration_us;

  logic          accept;
  logic          in_range;
  logic          hit;
  logic          a_edge;
  logic          b_edge;
  logic          emit_single;
  logic          emit_dual;
  logic          emit;
  logic [TIME_W-1:0]    ref_time;
  logic [LATENCY_W-1:0] lat;
  store_req_t    store_req;

  // configuration writes are taken whenever out of reset
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_DUAL;
      trig_sel   <= EDGE_RISE;
      pulse_line <= ACK_LINE_RESET;
      pulse_ms   <= ACK_MS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MODE:      mode       <= cfg.data[0];
        REG_TRIGGER:   trig_sel   <= cfg.data[1:0];
        REG_ACK_LINE:  pulse_line <= cfg.data[ACK_LINE_W-1:0];
        REG_ACK_PULSE: pulse_ms   <= cfg.data[ACK_MS_W-1:0];
        default: ;
      endcase
    end
  end

  // input side: take a reading whenever the result register can move
  assign in_ch.ready = !rst && (!out_valid || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = ALL_IN ||
                       ({1'b0, in_ch.line_id} < (LINE_ID_W + 1)'(LINES));

  always_comb begin
    store_req.write   = accept && in_range;
    store_req.src     = src_t'(in_ch.action);
    store_req.line_id = in_ch.line_id;
    store_req.value   = in_ch.sample_value;
  end

  elm_line_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (store_req),
    .trig_sel (trig_sel),
    .hit      (hit)
  );

  // edge decisions and the measured interval
  always_comb begin
    a_edge      = store_req.write && (in_ch.action == SRC_A) && hit;
    b_edge      = store_req.write && (in_ch.action == SRC_B) && hit;
    emit_single = a_edge && (mode == MODE_SINGLE);
    emit_dual   = b_edge && pending_valid;
    emit        = emit_single || emit_dual;
    ref_time    = emit_single ? previous_time : pending_time;
    lat         = sat_diff(in_ch.sample_time_us, ref_time);
  end

  // pending and previous edge marks
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_time   <= '0;
      pending_valid  <= 1'b0;
      previous_time  <= '0;
      previous_valid <= 1'b0;
    end else begin
      if (emit_single) begin
        previous_time  <= in_ch.sample_time_us;
        previous_valid <= 1'b1;
      end
      if (a_edge && (mode == MODE_DUAL)) begin
        pending_time  <= in_ch.sample_time_us;
        pending_valid <= 1'b1;
      end else if (emit_dual) begin
        pending_valid <= 1'b0;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= accept && emit;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      has_latency     <= emit_single ? previous_valid : 1'b1;
      latency_us      <= (emit_single && !previous_valid) ? '0 : lat;
      measure_time_us <= (emit_single && !previous_valid) ? '0 : in_ch.sample_time_us;
      ack_line_out    <= pulse_line;
      ack_duration_us <= ACK_US_W'(ACK_US_W'(pulse_ms) * ACK_US_W'(ACK_SCALE));
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.has_latency     = has_latency;
  assign out_ch.latency_us      = latency_us;
  assign out_ch.measure_time_us = measure_time_us;
  assign out_ch.fire_ack        = 1'b1;
  assign out_ch.ack_line_out    = ack_line_out;
  assign out_ch.ack_duration_us = ack_duration_us;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// self-checking testbench for the edge latency meter: directed cases, back pressure, random phases
`timescale 1ns / 100ps

module testbench;
  import elm_pkg::*;

  localparam int LINES         = DEFAULT_LINES;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 200;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 100;
  localparam int BURST_ITEMS   = 40;

  // trigger code outside the defined set, never qualifies
  localparam logic [1:0] EDGE_NONE = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam longint LAT_TOP    = 64'sd2147483647;
  localparam longint LAT_BOTTOM = -64'sd2147483648;

  typedef struct {
    logic                        has_latency;
    logic signed [LATENCY_W-1:0] latency_us;
    logic [TIME_W-1:0]           measure_time_us;
    logic                        fire_ack;
    logic [ACK_LINE_W-1:0]       ack_line_out;
    logic [ACK_US_W-1:0]         ack_duration_us;
  } meas_t;

  logic clk = 1'b0;
  logic rst;

  elm_in_if  in_ch ();
  elm_out_if out_ch ();
  elm_cfg_if cfg ();

  edge_latency_meter #(.LINES(LINES)) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always #6 clk = ~clk;

  // shadow of the block: configuration and kept state
  mode_t                 cur_mode;
  logic [1:0]            cur_trigger;
  logic [ACK_LINE_W-1:0] cur_ack_line;
  logic [ACK_MS_W-1:0]   cur_ack_ms;
  logic [SAMPLE_W-1:0]   kept_a [LINES];
  logic [SAMPLE_W-1:0]   kept_b [LINES];
  logic [TIME_W-1:0]     armed_time;
  logic                  armed;
  logic [TIME_W-1:0]     prior_time;
  logic                  prior_seen;
  meas_t                 due_meas [$];

  // values last offered per source and line, used to build no-change readings
  logic [SAMPLE_W-1:0] last_sent [2][LINES];

  int unsigned cycles = 0;
  int mismatches = 0;
  int readings_taken = 0;
  int regs_written = 0;
  int meas_checked = 0;
  int meas_with_latency = 0;

  // idling control
  int   stall_left = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  logic steady_in = 1'b0;
  logic steady_out = 1'b0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic is_edge(input logic [SAMPLE_W-1:0] was,
                                   input logic [SAMPLE_W-1:0] cur_val,
                                   input logic [1:0] trig);
    case (trig)
      EDGE_RISE: return (was == '0) && (cur_val != '0);
      EDGE_FALL: return (was != '0) && (cur_val == '0);
      EDGE_ANY:  return was != cur_val;
      default:   return 1'b0;
    endcase
  endfunction

  // later minus earlier, clipped to the signed 32-bit range
  function automatic logic signed [LATENCY_W-1:0] clamp_interval(
      input logic [TIME_W-1:0] later, input logic [TIME_W-1:0] earlier);
    longint span;
    span = longint'({1'b0, later}) - longint'({1'b0, earlier});
    if (span > LAT_TOP) span = LAT_TOP;
    else if (span < LAT_BOTTOM) span = LAT_BOTTOM;
    return LATENCY_W'(span);
  endfunction

  function automatic meas_t make_meas(input logic has,
                                      input logic signed [LATENCY_W-1:0] lat,
                                      input logic [TIME_W-1:0] at);
    meas_t m;
    m.has_latency     = has;
    m.latency_us      = has ? lat : '0;
    m.measure_time_us = has ? at : '0;
    m.fire_ack        = 1'b1;
    m.ack_line_out    = cur_ack_line;
    m.ack_duration_us = ACK_US_W'(cur_ack_ms * ACK_SCALE);
    return m;
  endfunction

  // expected measurement, if any, caused by one reading
  function automatic void measure_reading(input src_t src, input logic [LINE_ID_W-1:0] line,
                                          input logic [SAMPLE_W-1:0] val,
                                          input logic [TIME_W-1:0] t);
    logic hit;
    if (int'(line) >= LINES) return;
    if (src == SRC_A) begin
      hit = is_edge(kept_a[line], val, cur_trigger);
      kept_a[line] = val;
      if (hit && cur_mode == MODE_SINGLE) begin
        due_meas.push_back(make_meas(prior_seen,
                                     prior_seen ? clamp_interval(t, prior_time) : '0, t));
        prior_time = t;
        prior_seen = 1'b1;
      end else if (hit) begin
        armed_time = t;
        armed = 1'b1;
      end
    end else begin
      hit = is_edge(kept_b[line], val, cur_trigger);
      kept_b[line] = val;
      if (hit && armed) begin
        due_meas.push_back(make_meas(1'b1, clamp_interval(t, armed_time), t));
        armed = 1'b0;
      end
    end
  endfunction

  function automatic void compare_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // predict on every accepted reading
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      measure_reading(src_t'(in_ch.action), in_ch.line_id, in_ch.sample_value,
                      in_ch.sample_time_us);
      readings_taken++;
    end
  end

  // track register writes
  always @(posedge clk) begin
    if (!rst && cfg.valid && cfg.ready) begin
      regs_written++;
      case (cfg_reg_t'(cfg.index))
        REG_MODE:      cur_mode = mode_t'(cfg.data[0]);
        REG_TRIGGER:   cur_trigger = cfg.data[1:0];
        REG_ACK_LINE:  cur_ack_line = cfg.data[ACK_LINE_W-1:0];
        REG_ACK_PULSE: cur_ack_ms = cfg.data[ACK_MS_W-1:0];
        default: ;
      endcase
    end
  end

  // check every measurement transaction against the oldest expectation
  always @(posedge clk) begin
    meas_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (due_meas.size() == 0) begin
        $display("%0t: measurement with nothing expected, expected none, actual latency %0d",
                 $time, out_ch.latency_us);
        mismatches++;
      end else begin
        want = due_meas.pop_front();
        compare_field("has_latency", want.has_latency, out_ch.has_latency);
        compare_field("latency_us", want.latency_us, out_ch.latency_us);
        compare_field("measure_time_us", want.measure_time_us, out_ch.measure_time_us);
        compare_field("fire_ack", want.fire_ack, out_ch.fire_ack);
        compare_field("ack_line_out", want.ack_line_out, out_ch.ack_line_out);
        compare_field("ack_duration_us", want.ack_duration_us, out_ch.ack_duration_us);
        meas_checked++;
        if (want.has_latency) meas_with_latency++;
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      hold_seen <= hold_req;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      stall_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!steady_out && $urandom_range(0, 4) == 0) begin
      stall_left <= gap_len() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d measurements still due", cycles, due_meas.size());
      $display("[edge_latency_meter] ERROR");
      $finish;
    end
  end

  // one reading transaction, with an optional gap before it
  task automatic send_reading(input src_t src, input logic [LINE_ID_W-1:0] line,
                              input logic [SAMPLE_W-1:0] val, input logic [TIME_W-1:0] t);
    int gap;
    gap = (steady_in || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= src;
    in_ch.line_id        <= line;
    in_ch.sample_value   <= val;
    in_ch.sample_time_us <= t;
    last_sent[src][line] = val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering readings and let every due measurement come back
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    // let a clock edge pass so the last accepted reading has been predicted
    @(posedge clk);
    while (due_meas.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // dual line latency under reset settings, boundaries and saturation
  task automatic test_dual_latency();
    send_reading(SRC_B, 3, 32'd1, 63'd500);
    send_reading(SRC_A, 0, 32'd1, 63'd1000);
    send_reading(SRC_B, 0, 32'hFFFF_FFFF, 63'd1250);
    send_reading(SRC_A, 15, 32'hFFFF_FFFF, 63'd0);
    send_reading(SRC_B, 15, 32'h8000_0000, TIME_MAX);
    send_reading(SRC_A, 15, 32'd0, 63'd5);
    send_reading(SRC_A, 15, 32'd7, TIME_MAX);
    send_reading(SRC_B, 2, 32'd9, 63'd0);
    // exactly the largest and smallest latency that fit
    send_reading(SRC_A, 1, 32'd1, 63'd100);
    send_reading(SRC_B, 1, 32'd1, 63'd2147483747);
    send_reading(SRC_A, 1, 32'd0, 63'd200);
    send_reading(SRC_A, 1, 32'd1, 63'd2147483748);
    send_reading(SRC_B, 1, 32'd0, 63'd300);
    send_reading(SRC_B, 1, 32'd2, 63'd100);
  endtask

  // falling, any-change and the unused trigger code
  task automatic test_edge_kinds();
    wait_quiet();
    write_reg(REG_TRIGGER, CFG_DATA_W'(EDGE_FALL));
    send_reading(SRC_A, 4, 32'd3, 63'd1500);
    send_reading(SRC_A, 4, 32'd0, 63'd2000);
    send_reading(SRC_B, 0, 32'd0, 63'd1900);
    wait_quiet();
    write_reg(REG_TRIGGER, CFG_DATA_W'(EDGE_ANY));
    send_reading(SRC_A, 4, 32'h55, 63'd3000);
    send_reading(SRC_A, 4, 32'h55, 63'd3005);
    send_reading(SRC_B, 0, 32'h55, 63'd3010);
    wait_quiet();
    write_reg(REG_TRIGGER, CFG_DATA_W'(EDGE_NONE));
    send_reading(SRC_A, 4, 32'd0, 63'd4000);
    send_reading(SRC_B, 0, 32'd0, 63'd4010);
  endtask

  // single line intervals, first edge, and mode changes that keep state
  task automatic test_single_interval();
    wait_quiet();
    write_reg(REG_TRIGGER, CFG_DATA_W'(EDGE_ANY));
    write_reg(REG_MODE, CFG_DATA_W'(MODE_SINGLE));
    send_reading(SRC_A, 6, 32'd1, 63'd10);
    send_reading(SRC_A, 6, 32'd2, 63'd40);
    send_reading(SRC_B, 6, 32'd5, 63'd50);
    send_reading(SRC_A, 6, 32'd2, 63'd60);
    send_reading(SRC_A, 6, 32'd0, 63'd20);
    wait_quiet();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_DUAL));
    send_reading(SRC_A, 6, 32'd9, 63'd100);
    wait_quiet();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_SINGLE));
    send_reading(SRC_A, 6, 32'd0, 63'd120);
    send_reading(SRC_B, 6, 32'd0, 63'd130);
  endtask

  // acknowledge line and pulse length at their extremes, in and out of range
  task automatic ack_case(input logic [ACK_LINE_W-1:0] line, input logic [ACK_MS_W-1:0] ms,
                          input logic [TIME_W-1:0] t);
    wait_quiet();
    write_reg(REG_ACK_LINE, line);
    write_reg(REG_ACK_PULSE, CFG_DATA_W'(ms));
    send_reading(SRC_A, 7, ~last_sent[SRC_A][7], t);
  endtask

  task automatic test_ack_settings();
    ack_case(16'd0, 14'd0, 63'd1000);
    ack_case(16'hFFFF, 14'h3FFF, 63'd1001);
    ack_case(16'd1234, 14'd1, 63'd1002);
    ack_case(16'd8, 14'd10000, 63'd1003);
  endtask

  // receiver holds off while readings keep coming, then the sender waits for all results
  task automatic test_backpressure();
    wait_quiet();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_SINGLE));
    write_reg(REG_TRIGGER, CFG_DATA_W'(EDGE_ANY));
    steady_in = 1'b1;
    hold_req <= ~hold_req;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      send_reading(SRC_A, 9, i[0] ? 32'h0 : 32'hA5A5_0000 + i, 63'd5000 + 63'(i) * 63'd37);
    end
    steady_in = 1'b0;
    wait_quiet();
  endtask

  task automatic random_setup();
    logic [CFG_DATA_W-1:0] junk;
    logic                  m;
    logic [1:0]            tr;
    logic [ACK_LINE_W-1:0] al;
    logic [ACK_MS_W-1:0]   ms;
    int                    r;
    junk = CFG_DATA_W'($urandom());
    m  = 1'($urandom_range(0, 1));
    tr = ($urandom_range(0, 9) == 0) ? EDGE_NONE : 2'($urandom_range(0, 2));
    r  = $urandom_range(0, 9);
    al = (r == 0) ? '0 : (r == 1) ? '1 : ACK_LINE_W'($urandom());
    r  = $urandom_range(0, 9);
    ms = (r == 0) ? 14'd1 : (r == 1) ? 14'd10000 : (r == 2) ? 14'd0 : (r == 3) ? 14'h3FFF :
         ACK_MS_W'($urandom_range(1, 10000));
    // upper bits of the narrow registers carry noise
    write_reg(REG_MODE, {junk[CFG_DATA_W-1:1], m});
    write_reg(REG_TRIGGER, {junk[CFG_DATA_W-1:2], tr});
    write_reg(REG_ACK_LINE, al);
    write_reg(REG_ACK_PULSE, {junk[CFG_DATA_W-1:ACK_MS_W], ms});
  endtask

  // phases of random readings, each under a fresh random setting
  task automatic test_random_phases();
    logic [TIME_W-1:0]   clock_us;
    logic [TIME_W-1:0]   t;
    logic [SAMPLE_W-1:0] v;
    int                  line;
    int                  pick;
    src_t                src;
    clock_us = TIME_W'({$urandom(), $urandom()}) >> 2;
    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      random_setup();
      steady_in = ($urandom_range(0, 3) == 0);
      steady_out <= ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        src  = src_t'($urandom_range(0, 1));
        if (pick < 85) begin
          // well-formed traffic: few busy lines, time mostly moving forward
          line = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 3) : $urandom_range(0, LINES - 1);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: v = '0;
            4:          v = last_sent[src][line];
            default:    v = $urandom();
          endcase
          clock_us += ($urandom_range(0, 19) == 0) ? TIME_W'($urandom())
                                                   : TIME_W'($urandom_range(0, 3000));
          t = ($urandom_range(0, 19) == 0) ? clock_us - TIME_W'($urandom_range(0, 500))
                                           : clock_us;
        end else begin
          // noise: any line, any value, any timestamp
          line = $urandom_range(0, LINES - 1);
          v    = $urandom();
          t    = TIME_W'({$urandom(), $urandom()});
        end
        send_reading(src, LINE_ID_W'(line), v, t);
      end
    end
    steady_in = 1'b0;
    steady_out <= 1'b0;
  endtask

  initial begin
    rst                  <= 1'b1;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= SRC_A;
    in_ch.line_id        <= '0;
    in_ch.sample_value   <= '0;
    in_ch.sample_time_us <= '0;
    cfg.valid            <= 1'b0;
    cfg.index            <= REG_MODE;
    cfg.data             <= '0;

    // shadow starts from the reset state
    cur_mode     = MODE_DUAL;
    cur_trigger  = EDGE_RISE;
    cur_ack_line = ACK_LINE_RESET;
    cur_ack_ms   = ACK_MS_RESET;
    armed_time   = '0;
    armed        = 1'b0;
    prior_time   = '0;
    prior_seen   = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      kept_a[i] = '0;
      kept_b[i] = '0;
      last_sent[SRC_A][i] = '0;
      last_sent[SRC_B][i] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_dual_latency();
    test_edge_kinds();
    test_single_interval();
    test_ack_settings();
    test_backpressure();
    test_random_phases();
    wait_quiet();

    $display("covered %0d readings and %0d register writes over dual and single line modes",
             readings_taken, regs_written);
    $display("checked %0d measurements, %0d with a latency, %0d mismatches",
             meas_checked, meas_with_latency, mismatches);
    if (mismatches == 0) begin
      $display("[edge_latency_meter] OK");
    end else begin
      $display("[edge_latency_meter] ERROR");
    end
    $finish;
  end

endmodule
